### hw/rtl/rag_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rag_pkg: shared definitions for the region average grid filter
// Field widths, register indexes, and the controller/datapath command and
// status bundles.
// ---------------------------------------------------------------------------
package rag_pkg;

    localparam int PIX_W        = 8;
    localparam int SUM_W        = 12;
    localparam int CNT_W        = 4;
    localparam int ROW_W        = 12;
    localparam int HEIGHT_W     = 13;
    localparam int FW_CFG_W     = 11;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int MIN_SIZE     = 3;

    // floor(x / 9) == (x * RECIP_9) >> RECIP_SHIFT for x below 4096
    localparam logic [12:0] RECIP_9     = 13'd7282;
    localparam int          RECIP_SHIFT = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic k_clr;
        logic wr_pix;
        logic win_rd;
        logic win_chk;
        logic win_avg;
        logic upd_rd;
        logic upd_wr;
        logic adv;
        logic out_rd;
        logic out_ld;
        logic div_step;
        logic out_wr;
        logic out_done;
    } rag_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic take;
        logic win;
        logic k_win_done;
        logic ok;
        logic k_upd_last;
        logic emit;
        logic cnt_zero;
        logic div_done;
    } rag_status_t;

endpackage

### hw/rtl/rag_pix_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rag_pix_if: input item channel
// Valid/ready channel carrying mode and pixel.
// ---------------------------------------------------------------------------
interface rag_pix_if import rag_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output mode, output pixel, input ready);
    modport sink   (input valid, input mode, input pixel, output ready);
endinterface

### hw/rtl/rag_res_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rag_res_if: result item channel
// Valid/ready channel carrying the filtered pixel and the frame end mark.
// ---------------------------------------------------------------------------
interface rag_res_if import rag_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] result_pixel;
    logic             last;

    modport source (output valid, output result_pixel, output last, input ready);
    modport sink   (input valid, input result_pixel, input last, output ready);
endinterface

### hw/rtl/rag_cfg_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rag_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface rag_cfg_if import rag_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/region_average_grid_filter.sv
`timescale 1ns / 1ps
// Sequence: a pixel item is stored; when it closes a window the window is read and checked, and when
// that window is a region its nine cells are updated; a result with a nonzero count uses a 12-step divider.
// Throughput: one item at a time, set by the serial window read/update loop on the shared read port.
// Reset: after rst_n rises, a clearing pass over all 3*MAX_WIDTH cells zeroes the
// total/count store; no item is taken during it, configuration writes are.
// ---------------------------------------------------------------------------
// region_average_grid_filter: 3x3 region average filter on a raster stream
// Controller and datapath joined by command and status bundles.
// ---------------------------------------------------------------------------
module region_average_grid_filter import rag_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rag_pix_if.sink   pixels,
    rag_res_if.source results,
    rag_cfg_if.sink   cfg
);

    rag_cmd_t    cmd;
    rag_status_t st;
    logic        in_ready;
    logic        out_valid;

    assign pixels.ready  = in_ready;
    assign results.valid = out_valid;
    assign cfg.ready     = 1'b1;

    rag_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixels.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (results.ready),
        .st        (st),
        .cmd       (cmd)
    );

    rag_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .mode         (pixels.mode),
        .pixel        (pixels.pixel),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .result_pixel (results.result_pixel),
        .last         (results.last)
    );

endmodule

### hw/rtl/rag_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rag_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module rag_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/rag_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rag_ctrl: sequencer for the region average grid filter
// Steps one item through pixel store, window check, region update and
// output readout, issuing commands to the datapath.
// ---------------------------------------------------------------------------
module rag_ctrl import rag_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  rag_status_t st,
    output rag_cmd_t    cmd
);

    typedef enum logic [15:0] {
        S_CLEAR    = 16'b0000_0000_0000_0001,
        S_IDLE     = 16'b0000_0000_0000_0010,
        S_DECIDE   = 16'b0000_0000_0000_0100,
        S_WRPIX    = 16'b0000_0000_0000_1000,
        S_WIN_RD   = 16'b0000_0000_0001_0000,
        S_WIN_CHK  = 16'b0000_0000_0010_0000,
        S_WIN_AVG  = 16'b0000_0000_0100_0000,
        S_UPD_RD   = 16'b0000_0000_1000_0000,
        S_UPD_WR   = 16'b0000_0001_0000_0000,
        S_ADV      = 16'b0000_0010_0000_0000,
        S_OUT_CHK  = 16'b0000_0100_0000_0000,
        S_OUT_RD   = 16'b0000_1000_0000_0000,
        S_OUT_LD   = 16'b0001_0000_0000_0000,
        S_OUT_DIV  = 16'b0010_0000_0000_0000,
        S_OUT_WR   = 16'b0100_0000_0000_0000,
        S_OUT_HOLD = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT_HOLD);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    cmd.k_clr  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = st.take ? S_WRPIX : S_OUT_CHK;
            end
            S_WRPIX:
            begin
                cmd.wr_pix = 1'b1;
                cmd.k_clr  = 1'b1;
                state_next = st.win ? S_WIN_RD : S_ADV;
            end
            S_WIN_RD:
            begin
                cmd.win_rd = 1'b1;
                if (st.k_win_done)
                begin
                    state_next = S_WIN_CHK;
                end
            end
            S_WIN_CHK:
            begin
                cmd.win_chk = 1'b1;
                state_next  = S_WIN_AVG;
            end
            S_WIN_AVG:
            begin
                cmd.win_avg = 1'b1;
                cmd.k_clr   = 1'b1;
                state_next  = st.ok ? S_UPD_RD : S_ADV;
            end
            S_UPD_RD:
            begin
                cmd.upd_rd = 1'b1;
                state_next = S_UPD_WR;
            end
            S_UPD_WR:
            begin
                cmd.upd_wr = 1'b1;
                state_next = st.k_upd_last ? S_ADV : S_UPD_RD;
            end
            S_ADV:
            begin
                cmd.adv    = 1'b1;
                state_next = S_OUT_CHK;
            end
            S_OUT_CHK:
            begin
                state_next = st.emit ? S_OUT_RD : S_IDLE;
            end
            S_OUT_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                cmd.out_ld = 1'b1;
                cmd.k_clr  = 1'b1;
                state_next = st.cnt_zero ? S_OUT_WR : S_OUT_DIV;
            end
            S_OUT_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_done)
                begin
                    state_next = S_OUT_WR;
                end
            end
            S_OUT_WR:
            begin
                cmd.out_wr = 1'b1;
                state_next = S_OUT_HOLD;
            end
            S_OUT_HOLD:
            begin
                if (out_ready)
                begin
                    cmd.out_done = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/rag_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rag_datapath: storage and arithmetic of the region average grid filter
// Line stores, position counters, window check, region update and the
// serial divider for the output average.
// ---------------------------------------------------------------------------
module rag_datapath import rag_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rag_cmd_t               cmd,
    output rag_status_t            st,
    input  logic                   mode,
    input  logic [PIX_W-1:0]       pixel,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [PIX_W-1:0]       result_pixel,
    output logic                   last
);

    localparam int DEPTH   = 3 * MAX_WIDTH;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
    localparam int SC_W    = SUM_W + CNT_W;

    function automatic logic [1:0] slot_inc(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [1:0] s,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(32'(s) * MAX_WIDTH + 32'(c));
    endfunction

    function automatic logic [PIX_W-1:0] absd(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // registers
    logic [PIX_W-1:0]      thr_reg, thr_next;
    logic [FW_CFG_W-1:0]   fw_reg, fw_next;
    logic [HEIGHT_W-1:0]   fh_reg, fh_next;
    logic                  mode_reg, mode_next;
    logic [PIX_W-1:0]      pin_reg, pin_next;
    logic [WIDTH_W-1:0]    cur_w_reg, cur_w_next;
    logic [HEIGHT_W-1:0]   cur_h_reg, cur_h_next;
    logic [ROW_W-1:0]      in_row_reg, in_row_next;
    logic [COL_W-1:0]      in_col_reg, in_col_next;
    logic [1:0]            in_slot_reg, in_slot_next;
    logic                  done_reg, done_next;
    logic [ROW_W-1:0]      out_row_reg, out_row_next;
    logic [COL_W-1:0]      out_col_reg, out_col_next;
    logic [1:0]            out_slot_reg, out_slot_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    logic [3:0]            k_reg, k_next;
    logic [PIX_W-1:0]      win_reg [9];
    logic [PIX_W-1:0]      win_next [9];
    logic                  ok_reg, ok_next;
    logic [SUM_W-1:0]      sum9_reg, sum9_next;
    logic [PIX_W-1:0]      avg_reg, avg_next;
    logic [PIX_W-1:0]      opix_reg, opix_next;
    logic                  zero_reg, zero_next;
    logic [SUM_W-1:0]      dq_reg, dq_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      dvs_reg, dvs_next;
    logic [PIX_W-1:0]      res_reg, res_next;
    logic                  last_reg, last_next;

    // memory ports
    logic [PIX_W-1:0]  pix_rd;
    logic [SC_W-1:0]   sc_rd;
    logic              sc_we;
    logic [ADDR_W-1:0] sc_waddr;
    logic [SC_W-1:0]   sc_wdata;
    logic [ADDR_W-1:0] rd_addr;

    // addresses
    logic [1:0]        wi, wj, ws;
    logic [COL_W-1:0]  wc;
    logic [ADDR_W-1:0] win_addr, in_addr, out_addr;

    // window check
    logic              chk_ok;
    logic [SUM_W-1:0]  row_sum [3];
    logic [SUM_W-1:0]  chk_sum;
    logic [24:0]       avg_prod;

    // divider step
    logic [CNT_W:0]    rem_sh;
    logic              div_ge;

    // emit decision
    int unsigned       nr, nc;
    logic              frame_end;

    // window cell address from step index
    always_comb
    begin
        wi = (k_reg < 4'd3) ? 2'd0 : ((k_reg < 4'd6) ? 2'd1 : 2'd2);
        wj = 2'(k_reg - 4'(wi) * 4'd3);
        unique case (wi)
            2'd0:    ws = slot_inc(in_slot_reg);
            2'd1:    ws = slot_inc(slot_inc(in_slot_reg));
            default: ws = in_slot_reg;
        endcase
        wc       = COL_W'(32'(in_col_reg) + 32'(wj) - 32'd2);
        win_addr = cell_addr(ws, wc);
        in_addr  = cell_addr(in_slot_reg, in_col_reg);
        out_addr = cell_addr(out_slot_reg, out_col_reg);
    end

    // memory port selection
    always_comb
    begin
        rd_addr  = cmd.out_rd ? out_addr : win_addr;
        sc_we    = cmd.clr_step | cmd.upd_wr | cmd.out_wr;
        sc_waddr = cmd.clr_step ? clr_addr_reg : (cmd.out_wr ? out_addr : win_addr);
        sc_wdata = cmd.upd_wr ? {sc_rd[SC_W-1:CNT_W] + SUM_W'(avg_reg),
                                 sc_rd[CNT_W-1:0] + CNT_W'(1)} : '0;
    end

    rag_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_pix_ram (
        .clk   (clk),
        .we    (cmd.wr_pix),
        .waddr (in_addr),
        .wdata (pin_reg),
        .raddr (rd_addr),
        .rdata (pix_rd)
    );

    rag_ram #(.WIDTH(SC_W), .DEPTH(DEPTH)) u_sc_ram (
        .clk   (clk),
        .we    (sc_we),
        .waddr (sc_waddr),
        .wdata (sc_wdata),
        .raddr (rd_addr),
        .rdata (sc_rd)
    );

    // 12 adjacent pair checks and window sum
    always_comb
    begin
        chk_ok = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                if (absd(win_reg[i*3+j], win_reg[i*3+j+1]) > thr_reg)
                begin
                    chk_ok = 1'b0;
                end
                if (absd(win_reg[j*3+i], win_reg[(j+1)*3+i]) > thr_reg)
                begin
                    chk_ok = 1'b0;
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            row_sum[i] = SUM_W'(win_reg[i*3]) + SUM_W'(win_reg[i*3+1])
                       + SUM_W'(win_reg[i*3+2]);
        end
        chk_sum  = row_sum[0] + row_sum[1] + row_sum[2];
        avg_prod = 25'(sum9_reg) * 25'(RECIP_9);
    end

    // restoring divider step
    always_comb
    begin
        rem_sh = {rem_reg, dq_reg[SUM_W-1]};
        div_ge = (rem_sh >= {1'b0, dvs_reg});
    end

    // readiness of the pixel at the output position
    always_comb
    begin
        nr = (32'(out_row_reg) < 32'(cur_h_reg) - 32'd3) ? 32'(out_row_reg)
                                                          : 32'(cur_h_reg) - 32'd3;
        nc = (32'(out_col_reg) < 32'(cur_w_reg) - 32'd3) ? 32'(out_col_reg)
                                                          : 32'(cur_w_reg) - 32'd3;
        frame_end = (32'(out_row_reg) == 32'(cur_h_reg) - 32'd1)
                 && (32'(out_col_reg) == 32'(cur_w_reg) - 32'd1);
    end

    // status
    always_comb
    begin
        st.clr_done   = (clr_addr_reg == ADDR_W'(DEPTH - 1));
        st.take       = !mode_reg && !done_reg;
        st.win        = (in_row_reg >= ROW_W'(2)) && (in_col_reg >= COL_W'(2));
        st.k_win_done = (k_reg == 4'd9);
        st.ok         = ok_reg;
        st.k_upd_last = (k_reg == 4'd8);
        st.emit       = done_reg
                     || (32'(in_row_reg) > nr + 32'd2)
                     || ((32'(in_row_reg) == nr + 32'd2) && (32'(in_col_reg) > nc + 32'd2));
        st.cnt_zero   = (sc_rd[CNT_W-1:0] == '0);
        st.div_done   = (k_reg == 4'(SUM_W - 1));
    end

    // next state of the datapath registers
    always_comb
    begin
        thr_next      = thr_reg;
        fw_next       = fw_reg;
        fh_next       = fh_reg;
        mode_next     = mode_reg;
        pin_next      = pin_reg;
        cur_w_next    = cur_w_reg;
        cur_h_next    = cur_h_reg;
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        done_next     = done_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_slot_next = out_slot_reg;
        clr_addr_next = clr_addr_reg;
        k_next        = k_reg;
        win_next      = win_reg;
        ok_next       = ok_reg;
        sum9_next     = sum9_reg;
        avg_next      = avg_reg;
        opix_next     = opix_reg;
        zero_next     = zero_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        res_next      = res_reg;
        last_next     = last_reg;

        // register writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:    thr_next = cfg_data[PIX_W-1:0];
                REG_FRAME_WIDTH:  fw_next  = cfg_data[FW_CFG_W-1:0];
                REG_FRAME_HEIGHT: fh_next  = cfg_data;
                default:          ;
            endcase
        end

        if (cmd.clr_step && !st.clr_done)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
        end

        if (cmd.accept)
        begin
            mode_next = mode;
            pin_next  = pixel;
        end

        // step counter
        if (cmd.k_clr)
        begin
            k_next = '0;
        end
        else if (cmd.win_rd || cmd.upd_wr || cmd.div_step)
        begin
            k_next = k_reg + 4'd1;
        end

        // frame size is taken at the first pixel of a frame
        if (cmd.wr_pix && (in_row_reg == '0) && (in_col_reg == '0))
        begin
            if (fw_reg < FW_CFG_W'(MIN_SIZE))
                cur_w_next = WIDTH_W'(MIN_SIZE);
            else if (32'(fw_reg) > MAX_WIDTH)
                cur_w_next = WIDTH_W'(MAX_WIDTH);
            else
                cur_w_next = WIDTH_W'(fw_reg);
            if (fh_reg < HEIGHT_W'(MIN_SIZE))
                cur_h_next = HEIGHT_W'(MIN_SIZE);
            else if (32'(fh_reg) > MAX_HEIGHT)
                cur_h_next = HEIGHT_W'(MAX_HEIGHT);
            else
                cur_h_next = fh_reg;
        end

        // window capture, each cell taken the cycle after its read
        if (cmd.win_rd && (k_reg != 4'd0))
        begin
            win_next[k_reg - 4'd1] = pix_rd;
        end

        if (cmd.win_chk)
        begin
            ok_next   = chk_ok;
            sum9_next = chk_sum;
        end

        if (cmd.win_avg)
        begin
            avg_next = avg_prod[RECIP_SHIFT +: PIX_W];
        end

        // input position advance
        if (cmd.adv)
        begin
            if (32'(in_col_reg) + 32'd1 == 32'(cur_w_reg))
            begin
                in_col_next = '0;
                if (32'(in_row_reg) + 32'd1 == 32'(cur_h_reg))
                begin
                    in_row_next  = '0;
                    in_slot_next = 2'd0;
                    done_next    = 1'b1;
                end
                else
                begin
                    in_row_next  = in_row_reg + ROW_W'(1);
                    in_slot_next = slot_inc(in_slot_reg);
                end
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end

        // output readout
        if (cmd.out_ld)
        begin
            opix_next = pix_rd;
            zero_next = st.cnt_zero;
            dq_next   = sc_rd[SC_W-1:CNT_W];
            rem_next  = '0;
            dvs_next  = sc_rd[CNT_W-1:0];
        end

        if (cmd.div_step)
        begin
            dq_next  = {dq_reg[SUM_W-2:0], div_ge};
            rem_next = div_ge ? CNT_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[CNT_W-1:0];
        end

        if (cmd.out_wr)
        begin
            res_next  = zero_reg ? opix_reg : dq_reg[PIX_W-1:0];
            last_next = frame_end;
        end

        // output position advance; frame end restarts input
        if (cmd.out_done)
        begin
            if (last_reg)
            begin
                out_row_next  = '0;
                out_col_next  = '0;
                out_slot_next = 2'd0;
                in_row_next   = '0;
                in_col_next   = '0;
                in_slot_next  = 2'd0;
                done_next     = 1'b0;
            end
            else if (32'(out_col_reg) + 32'd1 == 32'(cur_w_reg))
            begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + ROW_W'(1);
                out_slot_next = slot_inc(out_slot_reg);
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= '0;
            fw_reg       <= FW_CFG_W'(MIN_SIZE);
            fh_reg       <= HEIGHT_W'(MIN_SIZE);
            mode_reg     <= 1'b0;
            cur_w_reg    <= WIDTH_W'(MIN_SIZE);
            cur_h_reg    <= HEIGHT_W'(MIN_SIZE);
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= 2'd0;
            done_reg     <= 1'b0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= 2'd0;
            clr_addr_reg <= '0;
            k_reg        <= '0;
            ok_reg       <= 1'b0;
            zero_reg     <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            thr_reg      <= thr_next;
            fw_reg       <= fw_next;
            fh_reg       <= fh_next;
            mode_reg     <= mode_next;
            cur_w_reg    <= cur_w_next;
            cur_h_reg    <= cur_h_next;
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            done_reg     <= done_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
            clr_addr_reg <= clr_addr_next;
            k_reg        <= k_next;
            ok_reg       <= ok_next;
            zero_reg     <= zero_next;
            last_reg     <= last_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pin_reg  <= pin_next;
        win_reg  <= win_next;
        sum9_reg <= sum9_next;
        avg_reg  <= avg_next;
        opix_reg <= opix_next;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        res_reg  <= res_next;
    end

    assign result_pixel = res_reg;
    assign last         = last_reg;

endmodule
